@@ rtl/core/swm_pkg.sv @@
package swm_pkg;

    localparam int MAX_WINDOW = 64;
    localparam int DATA_WIDTH = 32;
    localparam int LEN_WIDTH  = $clog2(MAX_WINDOW + 1);

    typedef logic signed [DATA_WIDTH-1:0] t_data;
    typedef logic [LEN_WIDTH-1:0]         t_len;

    // one deque candidate: its place in the row is its age
    typedef struct packed {
        logic  keep;
        t_data value;
    } t_cand;

    // zero acts as one, anything above the row length acts as the row length
    function automatic t_len clamp_len(input t_len raw);
        t_len res;
        if (raw == '0) begin
            res = t_len'(1);
        end else if (raw > t_len'(MAX_WINDOW)) begin
            res = t_len'(MAX_WINDOW);
        end else begin
            res = raw;
        end
        return res;
    endfunction

endpackage

@@ rtl/core/swm_if.sv @@
interface swm_sample_if;
    logic                valid;
    logic                ready;
    swm_pkg::t_data      sample;
    logic                start_of_sequence;

    modport source (output valid, output sample, output start_of_sequence, input ready);
    modport sink   (input valid, input sample, input start_of_sequence, output ready);
endinterface

interface swm_result_if;
    logic                valid;
    logic                ready;
    swm_pkg::t_data      window_max;

    modport source (output valid, output window_max, input ready);
    modport sink   (input valid, input window_max, output ready);
endinterface

interface swm_cfg_if;
    logic                valid;
    logic                ready;
    swm_pkg::t_len       window_len;

    modport source (output valid, output window_len, input ready);
    modport sink   (input valid, input window_len, output ready);
endinterface

@@ rtl/core/swm_cell.sv @@
module swm_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_advance,
    input  logic           i_flush,
    input  logic           i_in_window,
    input  swm_pkg::t_data i_sample,
    input  swm_pkg::t_cand i_prev,
    output swm_pkg::t_cand o_cand
);

    swm_pkg::t_cand r_cand;
    swm_pkg::t_cand n_cand;

    // a kept candidate moves on unless flushed, too old or beaten by the new item
    always_comb begin
        n_cand = r_cand;
        if (i_advance) begin
            n_cand.value = i_prev.value;
            n_cand.keep  = i_prev.keep & ~i_flush & i_in_window
                           & ~(i_prev.value < i_sample);
        end
    end

    // only the keep flag needs a reset, the value is don't-care while not kept
    always_ff @(posedge i_clk) begin
        r_cand.value <= n_cand.value;
        if (!i_rst_n) begin
            r_cand.keep <= 1'b0;
        end else begin
            r_cand.keep <= n_cand.keep;
        end
    end

    assign o_cand = r_cand;

endmodule

@@ rtl/core/swm_front_sel.sv @@
module swm_front_sel (
    input  swm_pkg::t_cand i_cells [swm_pkg::MAX_WINDOW],
    output swm_pkg::t_data o_front
);

    logic [swm_pkg::MAX_WINDOW-1:0] keep_vec;
    logic [swm_pkg::MAX_WINDOW-1:0] sel;

    for (genvar g = 0; g < swm_pkg::MAX_WINDOW; g++) begin : g_sel
        assign keep_vec[g] = i_cells[g].keep;
        if (g == swm_pkg::MAX_WINDOW - 1) begin : g_top
            assign sel[g] = keep_vec[g];
        end else begin : g_rest
            // oldest surviving candidate is the front of the deque
            assign sel[g] = keep_vec[g] & ~(|keep_vec[swm_pkg::MAX_WINDOW-1:g+1]);
        end
    end

    always_comb begin
        o_front = '0;
        for (int k = 0; k < swm_pkg::MAX_WINDOW; k++) begin
            o_front = o_front | (sel[k] ? i_cells[k].value : swm_pkg::t_data'(0));
        end
    end

endmodule

@@ rtl/core/sliding_window_maximum.sv @@
// Sliding-window maximum over a stream of signed 32-bit samples. Each accepted item
// gives one result, the maximum of the last window_len samples, once window_len items
// have been taken since reset or since the last item flagged start_of_sequence; before
// that an item gives no result. window_len is written through the configuration
// channel (reset value 1, 0 acts as 1, values above 64 act as 64) and takes effect
// from the next item. The deque lives in a row of 64 cells, one per sample age: each
// item moves every candidate one cell on, and all cells compare against the new sample
// at once, so one item is taken every clock cycle. A result appears in the cycle after
// its item is taken. Outside reset, the input stalls only while a result waits
// for the downstream side; the front candidate is picked straight from the cell
// row, so the row holds still while a result is pending.
module sliding_window_maximum (
    input  logic  i_clk,
    input  logic  i_rst_n,
    swm_sample_if.sink   i_sample_ch,
    swm_result_if.source o_result_ch,
    swm_cfg_if.sink      i_cfg_ch
);

    // configuration, stored already clamped
    swm_pkg::t_len r_window_len;

    // fill count since the start of the sequence
    swm_pkg::t_len r_seen;
    swm_pkg::t_len n_seen;
    swm_pkg::t_len seen_base;
    swm_pkg::t_len seen_inc;

    // result handshake
    logic r_out_valid;
    logic n_out_valid;

    logic in_ready;
    logic accept;

    // cell row
    swm_pkg::t_cand cand      [swm_pkg::MAX_WINDOW];
    swm_pkg::t_cand cand_prev [swm_pkg::MAX_WINDOW];
    logic [swm_pkg::MAX_WINDOW-1:0] in_window;
    swm_pkg::t_data front;

    // configuration is always taken outside reset
    assign i_cfg_ch.ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len <= swm_pkg::t_len'(1);
        end else if (i_cfg_ch.valid && i_cfg_ch.ready) begin
            r_window_len <= swm_pkg::clamp_len(i_cfg_ch.window_len);
        end
    end

    // a new item can enter whenever the result slot is free or being emptied
    assign in_ready          = i_rst_n && (!r_out_valid || o_result_ch.ready);
    assign i_sample_ch.ready = in_ready;
    assign accept            = i_sample_ch.valid && in_ready;

    // cell row: age g sits in cell g, a new sample always enters cell 0
    for (genvar g = 0; g < swm_pkg::MAX_WINDOW; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign cand_prev[g] = '{keep: 1'b1, value: i_sample_ch.sample};
            assign in_window[g] = 1'b1;
        end else begin : g_body
            assign cand_prev[g] = cand[g-1];
            // candidates reaching an age of window_len leave for good
            assign in_window[g] = swm_pkg::t_len'(g) < r_window_len;
        end

        swm_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_advance   (accept),
            .i_flush     ((g != 0) && i_sample_ch.start_of_sequence),
            .i_in_window (in_window[g]),
            .i_sample    (i_sample_ch.sample),
            .i_prev      (cand_prev[g]),
            .o_cand      (cand[g])
        );
    end

    swm_front_sel u_front_sel (
        .i_cells (cand),
        .o_front (front)
    );

    // fill count saturates at the window length, a shrunk window clamps it too
    always_comb begin
        seen_base = i_sample_ch.start_of_sequence ? '0 : r_seen;
        seen_inc  = seen_base + swm_pkg::t_len'(1);
        n_seen    = r_seen;
        if (accept) begin
            n_seen = (seen_inc > r_window_len) ? r_window_len : seen_inc;
        end
    end

    // result slot: filled by an item that completes a window, emptied when taken
    always_comb begin
        n_out_valid = r_out_valid && !o_result_ch.ready;
        if (accept) begin
            n_out_valid = (n_seen == r_window_len);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_seen      <= n_seen;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_result_ch.valid      = r_out_valid;
    assign o_result_ch.window_max = front;

endmodule

@@ rtl/core/swm_checker.sv @@
module swm_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           i_in_ready,
    input swm_pkg::t_data i_in_sample,
    input logic           i_in_start,
    input logic           i_out_valid,
    input logic           i_out_ready,
    input swm_pkg::t_data i_out_max,
    input logic           i_cfg_valid,
    input logic           i_cfg_ready,
    input swm_pkg::t_len  i_cfg_len
);

    swm_pkg::t_len r_len_shadow;
    logic          in_acc;
    logic          len_one;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_shadow <= swm_pkg::t_len'(1);
        end else if (i_cfg_valid && i_cfg_ready) begin
            r_len_shadow <= swm_pkg::clamp_len(i_cfg_len);
        end
    end

    assign in_acc  = i_in_valid && i_in_ready;
    assign len_one = (r_len_shadow == swm_pkg::t_len'(1));

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_max))
        else $error("pending result dropped or changed");

    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_start && !len_one |=> !i_out_valid)
        else $error("result given before a full window");

    a_len_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && len_one |=> i_out_valid && (i_out_max == $past(i_in_sample)))
        else $error("single-sample window must echo the sample");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input stalled without a waiting result");

endmodule

bind sliding_window_maximum swm_checker u_swm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_sample_ch.valid),
    .i_in_ready  (i_sample_ch.ready),
    .i_in_sample (i_sample_ch.sample),
    .i_in_start  (i_sample_ch.start_of_sequence),
    .i_out_valid (o_result_ch.valid),
    .i_out_ready (o_result_ch.ready),
    .i_out_max   (o_result_ch.window_max),
    .i_cfg_valid (i_cfg_ch.valid),
    .i_cfg_ready (i_cfg_ch.ready),
    .i_cfg_len   (i_cfg_ch.window_len)
);

@@ tb/swm_window_checker.sv @@
module swm_window_checker import swm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_smp_valid,
    input  logic  i_smp_ready,
    input  t_data i_smp_sample,
    input  logic  i_smp_sos,
    input  logic  i_res_valid,
    input  logic  i_res_ready,
    input  t_data i_res_max,
    input  logic  i_cfg_valid,
    input  logic  i_cfg_ready,
    input  t_len  i_cfg_len,
    output int    o_fail_count,
    output int    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // room for predicted results not yet taken
    localparam int EXP_DEPTH = 16;

    // candidate row of the predictor, oldest first
    t_data kept_value [MAX_WINDOW];
    int    kept_age   [MAX_WINDOW];
    int    kept_count  = 0;
    int    taken_count = 0;
    t_len  window_len_q = t_len'(1);

    // ring of expected results, oldest at exp_head
    t_data expected_ring [EXP_DEPTH];
    int    exp_head  = 0;
    int    exp_count = 0;
    int    fails = 0;

    function automatic int effective_window(input t_len raw);
        if (raw == '0) begin
            return 1;
        end
        if (int'(raw) > MAX_WINDOW) begin
            return MAX_WINDOW;
        end
        return int'(raw);
    endfunction

    // takes one sample, returns 1 when a full window has been seen
    function automatic bit advance_window_max(input t_data smp, input logic sos,
                                              output t_data front);
        int span;
        int drop;
        span = effective_window(window_len_q);
        drop = 0;
        if (sos) begin
            kept_count  = 0;
            taken_count = 0;
        end
        for (int i = 0; i < kept_count; i++) begin
            kept_age[i]++;
        end
        while (drop < kept_count && kept_age[drop] >= span) begin
            drop++;
        end
        if (drop > 0) begin
            for (int i = 0; i < kept_count - drop; i++) begin
                kept_value[i] = kept_value[i + drop];
                kept_age[i]   = kept_age[i + drop];
            end
            kept_count -= drop;
        end
        // equal entries stay, only strictly smaller ones go
        while (kept_count > 0 && kept_value[kept_count - 1] < smp) begin
            kept_count--;
        end
        if (kept_count >= MAX_WINDOW) begin
            kept_count = MAX_WINDOW - 1;
        end
        kept_value[kept_count] = smp;
        kept_age[kept_count]   = 0;
        kept_count++;
        taken_count++;
        if (taken_count > span) begin
            taken_count = span;
        end
        front = kept_value[0];
        return taken_count >= span;
    endfunction

    always @(posedge i_clk) begin : watch_channels
        t_data want;
        t_data front;
        if (!i_rst_n) begin
            window_len_q = t_len'(1);
            kept_count   = 0;
            taken_count  = 0;
            exp_head     = 0;
            exp_count    = 0;
        end else begin
            // results first: an item never gives its result at the edge it is taken
            if (i_res_valid && i_res_ready) begin
                if (exp_count == 0) begin
                    $display("%0t: unexpected window_max %0d, nothing expected",
                             $time, i_res_max);
                    fails++;
                end else begin
                    want      = expected_ring[exp_head];
                    exp_head  = (exp_head + 1) % EXP_DEPTH;
                    exp_count = exp_count - 1;
                    if (i_res_max !== want) begin
                        $display("%0t: window_max mismatch, expected %0d actual %0d",
                                 $time, want, i_res_max);
                        fails++;
                    end
                end
            end
            if (i_smp_valid && i_smp_ready) begin
                if (advance_window_max(i_smp_sample, i_smp_sos, front)) begin
                    if (exp_count == EXP_DEPTH) begin
                        $display("%0t: result backlog full, expected %0d actual none",
                                 $time, front);
                        fails++;
                    end else begin
                        expected_ring[(exp_head + exp_count) % EXP_DEPTH] = front;
                        exp_count = exp_count + 1;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                window_len_q = i_cfg_len;
            end
        end
        o_pending    <= exp_count;
        o_fail_count <= fails;
    end

endmodule

@@ tb/sliding_window_maximum_tb.sv @@
module sliding_window_maximum_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import swm_pkg::*;

    // receiver hold-off long enough to fill the block and stall its input
    localparam int LONG_HOLD     = 200;
    // idle cycles after the last result before a register write or the verdict
    localparam int SETTLE_CYCLES = 4;
    // rough number of random items per window setting
    localparam int PHASE_ITEMS   = 95;
    localparam int PICK_RANDOM   = -1;
    localparam int NUM_PHASES    = 14;
    // window settings of the random part, extremes among them
    localparam int PHASE_LENS [NUM_PHASES] =
        '{1, 64, 2, 0, 127, 5, 65, 3, 33, PICK_RANDOM, 8, 64, PICK_RANDOM, 1};

    localparam t_data DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam t_data DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    logic clk = 1'b0;
    logic rst_n;

    // handshake pacing, written by the stimulus process only
    int   hold_seq;
    logic rx_smooth;
    logic tx_smooth;

    int   pending;
    int   fail_count;

    swm_sample_if sample_ch ();
    swm_result_if result_ch ();
    swm_cfg_if    cfg_ch ();

    sliding_window_maximum DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_sample_ch (sample_ch),
        .o_result_ch (result_ch),
        .i_cfg_ch    (cfg_ch)
    );

    // watches all three channels, predicts every result and compares
    swm_window_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_smp_valid  (sample_ch.valid),
        .i_smp_ready  (sample_ch.ready),
        .i_smp_sample (sample_ch.sample),
        .i_smp_sos    (sample_ch.start_of_sequence),
        .i_res_valid  (result_ch.valid),
        .i_res_ready  (result_ch.ready),
        .i_res_max    (result_ch.window_max),
        .i_cfg_valid  (cfg_ch.valid),
        .i_cfg_ready  (cfg_ch.ready),
        .i_cfg_len    (cfg_ch.window_len),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 10 ns period
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // idle length: mostly short, now and then a long one
    function automatic int random_gap();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(10, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    // offer one item and hold it until taken, then maybe go idle for a while
    task automatic send_item(input t_data value, input logic sos);
        sample_ch.valid             <= 1'b1;
        sample_ch.sample            <= value;
        sample_ch.start_of_sequence <= sos;
        do @(posedge clk); while (!sample_ch.ready);
        if (!tx_smooth && $urandom_range(0, 2) == 0) begin
            sample_ch.valid <= 1'b0;
            repeat (random_gap()) @(posedge clk);
        end
    endtask

    // stop offering and wait until every predicted result has been taken
    task automatic drain_results();
        sample_ch.valid <= 1'b0;
        // let the checker count the last item taken before pending is read
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // register writes only while the block is idle
    task automatic write_window(input t_len len);
        drain_results();
        // idle gap before the write; an item that gave no result is already in the cell row
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.window_len <= len;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // receiver: random ready with short and long gaps, plus requested long holds
    initial begin
        int gap;
        int hold_seen;
        gap       = 0;
        hold_seen = 0;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_seq != hold_seen) begin
                hold_seen = hold_seq;
                gap       = LONG_HOLD;
            end
            if (gap > 0) begin
                result_ch.ready <= 1'b0;
                gap--;
            end else begin
                result_ch.ready <= 1'b1;
                if (!rx_smooth && $urandom_range(0, 2) == 0) begin
                    gap = random_gap();
                end
            end
        end
    end

    // stimulus
    initial begin
        int    eff;
        int    budget;
        int    seq_len;
        int    shape;
        int    kind;
        int    len_pick;
        t_data trend;
        t_data value;
        logic  sos;

        rst_n                       <= 1'b0;
        sample_ch.valid             <= 1'b0;
        sample_ch.sample            <= '0;
        sample_ch.start_of_sequence <= 1'b0;
        cfg_ch.valid                <= 1'b0;
        cfg_ch.window_len           <= '0;
        hold_seq                    <= 0;
        rx_smooth                   <= 1'b0;
        tx_smooth                   <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // window of one after reset: extremes of the sample
        send_item(DATA_MAX, 1'b0);
        send_item(DATA_MIN, 1'b1);
        send_item('0, 1'b0);
        send_item(-1, 1'b0);

        // zero length behaves as one
        write_window(t_len'(0));
        send_item(-5, 1'b1);
        send_item(3, 1'b0);

        // equal samples are all kept, then a larger one clears the tail
        write_window(t_len'(3));
        send_item(10, 1'b1);
        send_item(10, 1'b0);
        send_item(10, 1'b0);
        send_item(9, 1'b0);
        send_item(11, 1'b0);
        send_item(DATA_MIN, 1'b0);
        send_item(DATA_MIN, 1'b0);

        // length grows mid-stream, no new sequence
        write_window(t_len'(5));
        send_item(1, 1'b0);
        send_item(2, 1'b0);
        send_item(3, 1'b0);

        // length shrinks mid-stream: old front entries go, seen count clamped
        write_window(t_len'(2));
        send_item(4, 1'b0);
        send_item(0, 1'b0);

        // fresh sequence inside a running stream
        send_item(20, 1'b1);
        send_item(21, 1'b0);

        // random part: one window setting per phase
        for (int p = 0; p < NUM_PHASES; p++) begin
            len_pick = PHASE_LENS[p];
            if (len_pick == PICK_RANDOM) begin
                len_pick = $urandom_range(1, 127);
            end
            write_window(t_len'(len_pick));
            eff = (len_pick == 0) ? 1 : ((len_pick > MAX_WINDOW) ? MAX_WINDOW : len_pick);

            // first phase runs flat out on both sides
            tx_smooth <= (p == 0) || ($urandom_range(0, 3) == 0);
            rx_smooth <= (p == 0) || ($urandom_range(0, 3) == 0);
            // long receiver hold-off while items keep coming
            if (p == 2 || p == 11) begin
                hold_seq <= hold_seq + 1;
            end

            budget = PHASE_ITEMS;
            while (budget > 0) begin
                // mostly full sequences, some cut short, some carried on without a start
                kind = $urandom_range(0, 9);
                if (kind == 0) begin
                    seq_len = $urandom_range(1, eff);
                end else begin
                    seq_len = eff + $urandom_range(0, eff + 12);
                end
                shape = $urandom_range(0, 3);
                trend = t_data'($urandom);
                for (int k = 0; k < seq_len; k++) begin
                    case (shape)
                        0: begin
                            case ($urandom_range(0, 9))
                                0:       value = DATA_MAX;
                                1:       value = DATA_MIN;
                                2, 3, 4: value = t_data'(int'($urandom_range(0, 16)) - 8);
                                default: value = t_data'($urandom);
                            endcase
                        end
                        1: begin
                            // falling run fills the row, front ages out
                            trend = trend - t_data'($urandom_range(0, 40));
                            value = trend;
                        end
                        2: begin
                            trend = trend + t_data'($urandom_range(0, 40));
                            value = trend;
                        end
                        default: begin
                            // narrow range, many equal samples
                            value = t_data'(int'($urandom_range(0, 3)) - 1);
                        end
                    endcase
                    sos = (k == 0 && kind != 1) || ($urandom_range(0, 63) == 0);
                    send_item(value, sos);
                end
                budget -= seq_len;
                // now and then the sender pauses until every result is out
                if ($urandom_range(0, 7) == 0) begin
                    drain_results();
                end
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // guard against a hung handshake
    initial begin
        #8_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
